// File: hw/rtl/bti_pkg.sv
`timescale 1ns / 1ps

package bti_pkg;

    localparam int VAL_W = 32;
    localparam int WIDX_W = 8;
    localparam int CFG_W = 5;
    localparam int FRAC_BITS = 30;
    localparam int DEF_MAX_X_POINTS = 16;
    localparam int DEF_MAX_Y_POINTS = 16;
    localparam logic [CFG_W-1:0] RESET_POINT_COUNT = 5'd2;

    localparam logic [1:0] OP_WRITE_X = 2'd0;
    localparam logic [1:0] OP_WRITE_Y = 2'd1;
    localparam logic [1:0] OP_WRITE_Z = 2'd2;
    localparam logic [1:0] OP_EVAL    = 2'd3;

    localparam logic REG_X_POINT_COUNT = 1'b0;
    localparam logic REG_Y_POINT_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [WIDX_W-1:0]       write_index;
        logic signed [VAL_W-1:0] write_value;
        logic signed [VAL_W-1:0] query_x;
        logic signed [VAL_W-1:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] interp_value;
        logic                    zero_spacing;
    } t_out_item;

endpackage

// File: hw/rtl/bilinear_table_interpolator.sv
`timescale 1ns / 1ps
// Write commands produce no result and leave busy low.
// An evaluate transaction keeps busy high through the breakpoint scan (one read per
// cycle), a 30-step restoring divider per axis and three interpolations on one 34x17
// multiplier; the next transaction can start with the result.
// The result strobe is high in the first cycle with busy low; the receiver cannot stall.
// Synchronous active-low reset clears control state and sets both counts to 2.
module bilinear_table_interpolator #(
    parameter int MAX_X_POINTS = bti_pkg::DEF_MAX_X_POINTS,
    parameter int MAX_Y_POINTS = bti_pkg::DEF_MAX_Y_POINTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  bti_pkg::t_in_item            i_item,
    output logic                         o_result_valid,
    output bti_pkg::t_out_item           o_result,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [bti_pkg::CFG_W-1:0]    i_cfg_data
);
    import bti_pkg::*;

    localparam int XI_W = (MAX_X_POINTS > 1) ? $clog2(MAX_X_POINTS) : 1;
    localparam int YI_W = (MAX_Y_POINTS > 1) ? $clog2(MAX_Y_POINTS) : 1;
    localparam int IDX_W = (XI_W > YI_W) ? XI_W : YI_W;
    localparam int GRID_DEPTH = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GA_W = $clog2(GRID_DEPTH);
    localparam int MAXP = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
    localparam int CNT_W = $clog2(MAXP + 1);
    localparam int T_W = FRAC_BITS + 1;
    localparam int D_W = VAL_W + 2;
    localparam int M_W = D_W + 17;
    localparam int P_W = 66;
    localparam int R_W = P_W - FRAC_BITS + 0;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_CK0  = 4'd2;
    localparam logic [3:0] S_CKN  = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_LOW  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_AXD  = 4'd7;
    localparam logic [3:0] S_GA   = 4'd8;
    localparam logic [3:0] S_GB   = 4'd9;
    localparam logic [3:0] S_GC   = 4'd10;
    localparam logic [3:0] S_M0   = 4'd11;
    localparam logic [3:0] S_M1   = 4'd12;
    localparam logic [3:0] S_M2   = 4'd13;

    localparam logic [1:0] LERP_ROW0 = 2'd0;
    localparam logic [1:0] LERP_ROW1 = 2'd1;
    localparam logic [1:0] LERP_COL  = 2'd2;

    logic [VAL_W-1:0] r_xmem [MAX_X_POINTS];
    logic [VAL_W-1:0] r_ymem [MAX_Y_POINTS];
    logic [VAL_W-1:0] r_zmem [GRID_DEPTH];
    logic [VAL_W-1:0] r_xrd, r_yrd, r_zrd;

    logic [CFG_W-1:0] r_xcnt, r_ycnt;
    logic [3:0] r_state;
    logic r_axis, r_flag, r_valid;
    logic [CNT_W-1:0] r_nx, r_ny;
    logic signed [VAL_W-1:0] r_qx, r_qy, r_bhi;
    logic [IDX_W-1:0] r_i, r_lo, r_hi, r_xl, r_xh, r_yl, r_yh;
    logic [T_W-1:0] r_t, r_tx, r_ty;
    logic [VAL_W:0] r_rem, r_den;
    logic [4:0] r_cnt;
    logic [1:0] r_k;
    logic signed [D_W-1:0] r_a, r_d, r_r0;
    logic signed [P_W-1:0] r_acc;
    t_out_item r_out;

    logic accept;
    logic done;
    logic signed [VAL_W-1:0] q, bp_rd;
    logic [CNT_W-1:0] n;
    logic [IDX_W-1:0] nlast, bp_addr, col, row;
    logic found;
    logic signed [VAL_W:0] num, den, nn, dd;
    logic [VAL_W+1:0] rem2;
    logic ge;
    logic [31:0] z_flat;
    logic [GA_W-1:0] z_addr;
    logic [T_W-1:0] tsel;
    logic [16:0] tpart;
    logic signed [M_W-1:0] mul;
    logic signed [P_W-1:0] mul_ext, rnd;
    logic signed [R_W-1:0] lerp_res;
    logic [VAL_W-1:0] sat_res;
    logic [CNT_W-1:0] nx_eff, ny_eff;

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_result = r_out;

    always_comb begin
        nx_eff = (r_xcnt == '0) ? CNT_W'(1) :
                 ((32'(r_xcnt) > MAX_X_POINTS) ? CNT_W'(MAX_X_POINTS) : CNT_W'(r_xcnt));
        ny_eff = (r_ycnt == '0) ? CNT_W'(1) :
                 ((32'(r_ycnt) > MAX_Y_POINTS) ? CNT_W'(MAX_Y_POINTS) : CNT_W'(r_ycnt));
        q = r_axis ? r_qy : r_qx;
        n = r_axis ? r_ny : r_nx;
        bp_rd = r_axis ? $signed(r_yrd) : $signed(r_xrd);
        nlast = IDX_W'(32'(n) - 32'd1);
        found = (bp_rd >= q) || (r_i == nlast);
        unique case (r_state)
            S_CK0:   bp_addr = nlast;
            S_CKN:   bp_addr = IDX_W'(1);
            S_SCAN:  bp_addr = found ? (r_i - IDX_W'(1)) : (r_i + IDX_W'(1));
            default: bp_addr = '0;
        endcase
        num = {q[VAL_W-1], q} - {bp_rd[VAL_W-1], bp_rd};
        den = {r_bhi[VAL_W-1], r_bhi} - {bp_rd[VAL_W-1], bp_rd};
        nn = den[VAL_W] ? -num : num;
        dd = den[VAL_W] ? -den : den;
        rem2 = {r_rem, 1'b0};
        ge = (rem2 >= {1'b0, r_den});
        if (r_state == S_GA) begin
            col = r_xl;
            row = (r_k == LERP_ROW0) ? r_yl : r_yh;
        end else begin
            col = r_xh;
            row = (r_k == LERP_ROW0) ? r_yl : r_yh;
        end
        z_flat = 32'(col) + 32'(r_nx) * 32'(row);
        z_addr = z_flat[GA_W-1:0];
        tsel = (r_k == LERP_COL) ? r_ty : r_tx;
        tpart = (r_state == S_M0) ? {1'b0, tsel[15:0]} : {2'b00, tsel[T_W-1:16]};
        mul = r_d * $signed(tpart);
        mul_ext = {{(P_W-M_W){mul[M_W-1]}}, mul};
        rnd = r_acc + (P_W'(1) <<< (FRAC_BITS - 1));
        lerp_res = {{(R_W-D_W){r_a[D_W-1]}}, r_a} + rnd[P_W-1:FRAC_BITS];
        if (lerp_res > R_W'(32'sh7fffffff)) begin
            sat_res = 32'h7fffffff;
        end else if (lerp_res < -(R_W'(33'sh080000000))) begin
            sat_res = 32'h80000000;
        end else begin
            sat_res = lerp_res[VAL_W-1:0];
        end
        done = ((r_state == S_AXD) && r_axis && r_flag)
            || ((r_state == S_M2) && (r_k == LERP_COL));
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.opcode == OP_WRITE_X
                && 32'(i_item.write_index) < MAX_X_POINTS) begin
            r_xmem[i_item.write_index[XI_W-1:0]] <= i_item.write_value;
        end
        if (accept && i_item.opcode == OP_WRITE_Y
                && 32'(i_item.write_index) < MAX_Y_POINTS) begin
            r_ymem[i_item.write_index[YI_W-1:0]] <= i_item.write_value;
        end
        if (accept && i_item.opcode == OP_WRITE_Z
                && 32'(i_item.write_index) < GRID_DEPTH) begin
            r_zmem[GA_W'(i_item.write_index)] <= i_item.write_value;
        end
        r_xrd <= r_xmem[bp_addr[XI_W-1:0]];
        r_yrd <= r_ymem[bp_addr[YI_W-1:0]];
        r_zrd <= r_zmem[z_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xcnt  <= RESET_POINT_COUNT;
            r_ycnt  <= RESET_POINT_COUNT;
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_axis  <= 1'b0;
            r_flag  <= 1'b0;
            r_k     <= LERP_ROW0;
            r_cnt   <= '0;
        end else begin
            r_valid <= done;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_X_POINT_COUNT) begin
                    r_xcnt <= i_cfg_data;
                end else begin
                    r_ycnt <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_item.opcode == OP_EVAL) begin
                        r_qx    <= i_item.query_x;
                        r_qy    <= i_item.query_y;
                        r_nx    <= nx_eff;
                        r_ny    <= ny_eff;
                        r_axis  <= 1'b0;
                        r_flag  <= 1'b0;
                        r_state <= S_RD0;
                    end
                end
                S_RD0: r_state <= S_CK0;
                S_CK0: begin
                    if (q <= bp_rd) begin
                        r_lo    <= '0;
                        r_hi    <= '0;
                        r_t     <= '0;
                        r_state <= S_AXD;
                    end else begin
                        r_state <= S_CKN;
                    end
                end
                S_CKN: begin
                    if (q >= bp_rd) begin
                        r_lo    <= nlast;
                        r_hi    <= nlast;
                        r_t     <= '0;
                        r_state <= S_AXD;
                    end else begin
                        r_i     <= IDX_W'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        r_hi    <= r_i;
                        r_lo    <= r_i - IDX_W'(1);
                        r_bhi   <= bp_rd;
                        r_state <= S_LOW;
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                S_LOW: begin
                    if (den == '0) begin
                        r_flag  <= 1'b1;
                        r_t     <= '0;
                        r_state <= S_AXD;
                    end else if (nn <= 0) begin
                        r_t     <= '0;
                        r_state <= S_AXD;
                    end else if (nn >= dd) begin
                        r_t     <= {1'b1, {FRAC_BITS{1'b0}}};
                        r_state <= S_AXD;
                    end else begin
                        r_rem   <= nn;
                        r_den   <= dd;
                        r_t     <= '0;
                        r_cnt   <= 5'(FRAC_BITS);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? (rem2[VAL_W:0] - r_den) : rem2[VAL_W:0];
                    r_t   <= {r_t[T_W-2:0], ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_state <= S_AXD;
                    end
                end
                S_AXD: begin
                    if (!r_axis) begin
                        r_xl    <= r_lo;
                        r_xh    <= r_hi;
                        r_tx    <= r_t;
                        r_axis  <= 1'b1;
                        r_state <= S_RD0;
                    end else begin
                        r_yl <= r_lo;
                        r_yh <= r_hi;
                        r_ty <= r_t;
                        if (r_flag) begin
                            r_out.interp_value <= '0;
                            r_out.zero_spacing <= 1'b1;
                            r_state            <= S_IDLE;
                        end else begin
                            r_k     <= LERP_ROW0;
                            r_state <= S_GA;
                        end
                    end
                end
                S_GA: r_state <= S_GB;
                S_GB: begin
                    r_a     <= D_W'($signed(r_zrd));
                    r_state <= S_GC;
                end
                S_GC: begin
                    r_d     <= D_W'($signed(r_zrd)) - r_a;
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_acc   <= mul_ext;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= r_acc + {mul_ext[P_W-17:0], 16'b0};
                    r_state <= S_M2;
                end
                S_M2: begin
                    if (r_k == LERP_ROW0) begin
                        r_r0    <= lerp_res[D_W-1:0];
                        r_k     <= LERP_ROW1;
                        r_state <= S_GA;
                    end else if (r_k == LERP_ROW1) begin
                        r_a     <= r_r0;
                        r_d     <= lerp_res[D_W-1:0] - r_r0;
                        r_k     <= LERP_COL;
                        r_state <= S_M0;
                    end else begin
                        r_out.interp_value <= sat_res;
                        r_out.zero_spacing <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_eval_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.opcode == OP_EVAL) |=> busy)
        else $error("evaluate transaction did not start the sequencer");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.opcode != OP_EVAL) |=> !o_result_valid && !busy)
        else $error("write transaction produced a result");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.zero_spacing) |-> (o_result.interp_value == '0))
        else $error("zero spacing result carries a nonzero value");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 5'd0))
        else $error("divider running with an exhausted step count");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bti_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_item i_item = '0;
    logic o_result_valid;
    t_out_item o_result;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    bilinear_table_interpolator DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_result_valid(o_result_valid),
        .o_result(o_result),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    longint x_bp[16];
    longint y_bp[16];
    longint z_cells[256];
    logic [CFG_W-1:0] x_count;
    logic [CFG_W-1:0] y_count;
    t_out_item pending_results[$];
    int errors = 0;
    int idle_pct = 13;
    int unsigned cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_result);
                errors++;
            end else begin
                if (o_result.interp_value !== pending_results[0].interp_value ||
                    o_result.zero_spacing !== pending_results[0].zero_spacing) begin
                    $display("%0t: expected value %h flag %b, got value %h flag %b", $time,
                             pending_results[0].interp_value, pending_results[0].zero_spacing,
                             o_result.interp_value, o_result.zero_spacing);
                    errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    function automatic int clamp_count(logic [CFG_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > 16) return 16;
        return raw;
    endfunction

    function automatic bit find_edge_or_bin(input longint bp[16], input int n, input longint q,
                                            output int idx);
        int i;
        if (q <= bp[0]) begin
            idx = 0;
            return 1'b1;
        end
        if (q >= bp[n-1]) begin
            idx = n - 1;
            return 1'b1;
        end
        for (i = 1; i < n - 1; i++)
            if (bp[i] >= q) break;
        idx = i;
        return 1'b0;
    endfunction

    function automatic bit span_fraction(input longint num, input longint den, output longint t);
        t = 0;
        if (den == 0) return 1'b0;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        if (num <= 0) t = 0;
        else if (num >= den) t = 64'sd1 << 30;
        else t = (num <<< 30) / den;
        return 1'b1;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        longint p;
        p = (b - a) * t;
        return a + ((p + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function automatic t_out_item interpolate(longint qx, longint qy);
        t_out_item r;
        int nx, ny, ix, iy;
        bit xp, yp, ok;
        longint v, tx, ty, r0, r1;
        nx = clamp_count(x_count);
        ny = clamp_count(y_count);
        xp = find_edge_or_bin(x_bp, nx, qx, ix);
        yp = find_edge_or_bin(y_bp, ny, qy, iy);
        ok = 1'b1;
        tx = 0;
        ty = 0;
        if (!xp) ok = span_fraction(qx - x_bp[ix-1], x_bp[ix] - x_bp[ix-1], tx) && ok;
        if (!yp) ok = span_fraction(qy - y_bp[iy-1], y_bp[iy] - y_bp[iy-1], ty) && ok;
        if (!ok) v = 0;
        else if (xp && yp) v = z_cells[ix + nx*iy];
        else if (xp) v = blend(z_cells[ix + nx*(iy-1)], z_cells[ix + nx*iy], ty);
        else if (yp) v = blend(z_cells[ix-1 + nx*iy], z_cells[ix + nx*iy], tx);
        else begin
            r0 = blend(z_cells[ix-1 + nx*(iy-1)], z_cells[ix + nx*(iy-1)], tx);
            r1 = blend(z_cells[ix-1 + nx*iy], z_cells[ix + nx*iy], tx);
            v = blend(r0, r1, ty);
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.interp_value = v[31:0];
        r.zero_spacing = !ok;
        return r;
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] op, logic [7:0] idx, logic [31:0] val,
                                          logic [31:0] qx, logic [31:0] qy);
        t_in_item c;
        c.opcode = op;
        c.write_index = idx;
        c.write_value = val;
        c.query_x = qx;
        c.query_y = qy;
        return c;
    endfunction

    // Issues one transaction; once taken, updates the model or queues its result.
    task automatic issue(t_in_item c, bit typed = 1'b0, t_out_item typed_res = '0);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= c;
        do @(posedge i_clk); while (busy);
        case (c.opcode)
            OP_WRITE_X: if (c.write_index < 16) x_bp[c.write_index] = c.write_value;
            OP_WRITE_Y: if (c.write_index < 16) y_bp[c.write_index] = c.write_value;
            OP_WRITE_Z: z_cells[c.write_index] = c.write_value;
            OP_EVAL: begin
                if (typed) pending_results.insert(pending_results.size(), typed_res);
                else pending_results.insert(pending_results.size(),
                                            interpolate(c.query_x, c.query_y));
            end
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [CFG_W-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_X_POINT_COUNT) x_count = data;
        else y_count = data;
    endtask

    task automatic load_axis(logic [1:0] op, int n);
        longint p;
        int i;
        bit sorted;
        sorted = $urandom_range(99) < 85;
        p = longint'($signed($urandom)) >>> $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            if (sorted) begin
                issue(make_cmd(op, 8'(i), p[31:0], $urandom, $urandom));
                p += $urandom_range(1, 1 << $urandom_range(0, 26));
            end else begin
                issue(make_cmd(op, 8'(i), $urandom, $urandom, $urandom));
            end
        end
    endtask

    function automatic logic [31:0] pick_coord(input longint bp[16], input int n);
        int k;
        longint lo, hi;
        k = $urandom_range(n - 1);
        lo = bp[k];
        hi = bp[(k + 1) % n];
        if (lo > hi) begin
            lo = hi;
            hi = bp[k];
        end
        case ($urandom_range(5))
            0: return bp[k][31:0];
            1: return 32'(bp[k] + $signed($urandom_range(2)) - 1);
            2: return $urandom;
            3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(lo + longint'($urandom) % (hi - lo + 1));
        endcase
    endfunction

    typedef struct {
        t_in_item cmd;
        bit typed;
        t_out_item res;
    } t_row;

    t_row directed[] = '{
        '{make_cmd(OP_WRITE_X, 0, 32'h0, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_X, 1, 32'h10000, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Y, 0, 32'h0, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Y, 1, 32'h10000, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Z, 0, 32'h7fffffff, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Z, 1, 32'h80000000, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Z, 2, 32'h10000, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Z, 3, 32'h0, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Z, 255, 32'hffffffff, 0, 0), 0, '0},
        '{make_cmd(OP_EVAL, 0, 0, 32'h0, 32'h0), 1, '{32'h7fffffff, 1'b0}},
        '{make_cmd(OP_EVAL, 0, 0, 32'h10000, 32'h0), 1, '{32'h80000000, 1'b0}},
        '{make_cmd(OP_EVAL, 0, 0, 32'h80000000, 32'h7fffffff), 1, '{32'h10000, 1'b0}},
        '{make_cmd(OP_EVAL, 8'hff, 32'hffffffff, 32'h7fffffff, 32'h7fffffff), 1, '{0, 1'b0}},
        '{make_cmd(OP_EVAL, 0, 0, 32'h8000, 32'h80000000), 0, '0},
        '{make_cmd(OP_EVAL, 0, 0, 32'h80000000, 32'h8000), 0, '0},
        '{make_cmd(OP_EVAL, 0, 0, 32'h8000, 32'h8000), 0, '0},
        '{make_cmd(OP_EVAL, 0, 0, 32'h1, 32'hffff), 0, '0},
        '{make_cmd(OP_WRITE_X, 200, 32'h5555, 0, 0), 0, '0},
        '{make_cmd(OP_WRITE_Y, 255, 32'h5555, 0, 0), 0, '0},
        '{make_cmd(OP_EVAL, 0, 0, 32'h4000, 32'hc000), 0, '0},
        '{make_cmd(OP_WRITE_X, 1, 32'hffff0000, 0, 0), 0, '0},
        '{make_cmd(OP_EVAL, 0, 0, 32'hffff8000, 32'h4000), 0, '0}
    };

    int x_cfgs[12] = '{1, 31, 16, 0, 3, 5, 2, 14, 4, 6, 16, 7};
    int y_cfgs[12] = '{1, 2, 14, 5, 16, 3, 31, 0, 4, 2, 4, 6};

    initial begin
        int ph, k, nx, ny;
        x_count = RESET_POINT_COUNT;
        y_count = RESET_POINT_COUNT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[r]) issue(directed[r].cmd, directed[r].typed, directed[r].res);
        for (ph = 0; ph < 12; ph++) begin
            idle_pct = (ph < 4) ? 13 : (ph < 8) ? 81 : 0;
            write_cfg(REG_X_POINT_COUNT, CFG_W'(x_cfgs[ph]));
            write_cfg(REG_Y_POINT_COUNT, CFG_W'(y_cfgs[ph]));
            nx = clamp_count(x_count);
            ny = clamp_count(y_count);
            load_axis(OP_WRITE_X, nx);
            load_axis(OP_WRITE_Y, ny);
            for (k = 0; k < nx * ny; k++)
                issue(make_cmd(OP_WRITE_Z, 8'(k), $urandom_range(3) == 0 ?
                               ($urandom_range(1) ? 32'h7fffffff : 32'h80000000) : $urandom,
                               $urandom, $urandom));
            for (k = 0; k < 34; k++) begin
                if ($urandom_range(99) < 12)
                    issue(make_cmd(2'($urandom_range(2)), 8'($urandom), $urandom, $urandom,
                                   $urandom));
                else
                    issue(make_cmd(OP_EVAL, 8'($urandom), $urandom,
                                   pick_coord(x_bp, nx), pick_coord(y_bp, ny)));
            end
        end
        drain();
        repeat (200) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/bti_pkg.sv
hw/rtl/bilinear_table_interpolator.sv
tb/testbench.sv
